@@ src/msw_pkg.sv @@
// Package for the media segment window index: sizes, command codes, register map,
// the control structs between the top level and the segment ring, and the
// seconds rounding function. No dependencies.
package msw_pkg;

  // Window and part list depths; the ring wraps by bit truncation, so
  // WINDOW_DEPTH stays a power of two.
  localparam int WINDOW_DEPTH = 16;
  localparam int PART_DEPTH   = 16;
  localparam int SLOT_W       = $clog2(WINDOW_DEPTH);
  localparam int COUNT_W      = $clog2(WINDOW_DEPTH + 1);
  localparam int PCOUNT_W     = $clog2(PART_DEPTH + 1);

  // Command codes
  localparam logic [2:0] CMD_PUSH_SEG  = 3'd0;
  localparam logic [2:0] CMD_PUSH_PART = 3'd1;
  localparam logic [2:0] CMD_CLOSE     = 3'd2;
  localparam logic [2:0] CMD_QUERY     = 3'd3;
  localparam logic [2:0] CMD_ENABLE_LL = 3'd4;

  // Register map (word index) and reset value
  localparam logic       REG_MAX_SEGMENTS   = 1'b0;
  localparam logic [4:0] MAX_SEGMENTS_RESET = 5'd6;
  localparam logic [4:0] MIN_SEGMENTS       = 5'd2;

  // Status codes
  localparam logic ST_ACCEPTED  = 1'b0;
  localparam logic ST_PART_FULL = 1'b1;

  // Reciprocal of 1000 scaled by 2^27, rounded up; exact for values below 2^17.
  localparam int          RECIP_SHIFT = 27;
  localparam logic [17:0] RECIP_1000  = 18'd134218;

  typedef struct packed {
    logic                push;
    logic [PCOUNT_W-1:0] parts;
    logic [COUNT_W-1:0]  limit;
  } ring_req_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [31:0]        oldest;
    logic [COUNT_W-1:0] count_next;
    logic [31:0]        oldest_next;
    logic               hit;
  } ring_stat_t;

  // ceil(ms / 1000), at least 1
  function automatic logic [6:0] ceil_seconds(input logic [15:0] ms);
    logic [16:0] biased;
    logic [34:0] prod;
    logic [6:0]  secs;
    biased = 17'(ms) + 17'd999;
    prod   = 35'(biased) * 35'(RECIP_1000);
    secs   = prod[RECIP_SHIFT +: 7];
    return (secs == 7'd0) ? 7'd1 : secs;
  endfunction

endpackage

@@ src/msw_in_if.sv @@
// Command channel of the media segment window index.
// Depends on nothing; payload widths follow the command item fields.
interface msw_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [26:0] size_bytes;
  logic [15:0] duration_ms;
  logic        independent;
  logic [31:0] query_seq;
  logic [7:0]  query_part;

  modport source (output valid, command, size_bytes, duration_ms, independent,
                  query_seq, query_part, input ready);
  modport sink (input valid, command, size_bytes, duration_ms, independent,
                query_seq, query_part, output ready);
endinterface

@@ src/msw_out_if.sv @@
// Result channel of the media segment window index.
// Depends on nothing; payload widths follow the result item fields.
interface msw_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [31:0] seq_out;
  logic [47:0] seg_start;
  logic [31:0] part_offset;
  logic        available;
  logic [6:0]  target_duration_s;
  logic        store_ready;
  logic        ll_ready;
  logic [31:0] first_held_seq;
  logic [4:0]  segment_count;

  modport source (output valid, status, seq_out, seg_start, part_offset, available,
                  target_duration_s, store_ready, ll_ready, first_held_seq,
                  segment_count, input ready);
  modport sink (input valid, status, seq_out, seg_start, part_offset, available,
                target_duration_s, store_ready, ll_ready, first_held_seq,
                segment_count, output ready);
endinterface

@@ src/msw_ring.sv @@
// Segment ring of the media segment window index: head, count, oldest sequence
// and the per-slot part counts, plus the range check and lookup for part queries.
// Depends on msw_pkg.
module msw_ring (
  input  logic                clk,
  input  logic                rst,
  input  msw_pkg::ring_req_t  req,
  input  logic [31:0]         query_seq,
  input  logic [7:0]          query_part,
  output msw_pkg::ring_stat_t stat
);

  logic [msw_pkg::SLOT_W-1:0]   head;
  logic [msw_pkg::SLOT_W-1:0]   head_next;
  logic [msw_pkg::COUNT_W-1:0]  count;
  logic [msw_pkg::COUNT_W-1:0]  count_next;
  logic [31:0]                  oldest;
  logic [31:0]                  oldest_next;
  logic [msw_pkg::PCOUNT_W-1:0] parts_mem [msw_pkg::WINDOW_DEPTH];

  logic                         evict;
  logic [msw_pkg::COUNT_W-1:0]  kept;
  logic [msw_pkg::SLOT_W-1:0]   wr_slot;
  logic [msw_pkg::SLOT_W-1:0]   rd_slot;
  logic [31:0]                  last_seq;
  logic [31:0]                  rel;
  logic                         in_range;
  logic [msw_pkg::PCOUNT_W-1:0] rd_parts;

  // Push: drop the oldest slot first when the window is full.
  always_comb begin
    evict       = req.push && (count >= req.limit);
    head_next   = evict ? head + msw_pkg::SLOT_W'(1) : head;
    kept        = evict ? count - msw_pkg::COUNT_W'(1) : count;
    oldest_next = evict ? oldest + 32'd1 : oldest;
    wr_slot     = head_next + kept[msw_pkg::SLOT_W-1:0];
    count_next  = req.push ? kept + msw_pkg::COUNT_W'(1) : count;
  end

  // Query against the held range; the last sequence wraps at 32 bits, so a
  // wrapped range holds nothing.
  always_comb begin
    last_seq = oldest + 32'(count) - 32'd1;
    in_range = (count != '0) && (query_seq >= oldest) && (query_seq <= last_seq);
    rel      = query_seq - oldest;
    rd_slot  = head + rel[msw_pkg::SLOT_W-1:0];
    rd_parts = parts_mem[rd_slot];
  end

  always_comb begin
    stat.count       = count;
    stat.oldest      = oldest;
    stat.count_next  = count_next;
    stat.oldest_next = oldest_next;
    stat.hit         = in_range && ((query_part == 8'd0) || (8'(rd_parts) > query_part));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      count  <= '0;
      oldest <= '0;
    end else begin
      head   <= head_next;
      count  <= count_next;
      oldest <= oldest_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req.push) begin
      parts_mem[wr_slot] <= req.parts;
    end
  end

endmodule

@@ src/media_segment_window_index.sv @@
// Media segment window index: top level.
// Depends on msw_pkg, msw_in_if, msw_out_if and msw_ring.
//
// Usage:
//   item   - command channel (valid/ready). One transaction carries one command:
//            push segment, push part, close live segment, query part, or
//            enable low latency, with its size, duration and query fields.
//   result - result channel (valid/ready). Exactly one result transaction per
//            command, in command order.
//   APB    - one register, max_segments at byte address 0 (window size,
//            clamped to 2..16). Write it only while the block is idle.
// Latency: a result is offered on the cycle after its command is accepted.
// Throughput: one command per cycle while the result channel takes results.
// The whole command (ring update, counter updates, query lookup and the
// seconds rounding multiply) is a single pass of logic into the result register.
// Stalls: the result register parts the channels; while a result waits
// untaken, item.ready is low, and it rises in the cycle the result is taken.
// Reset: rst is synchronous; the window, live segment, counters and the
// low-latency flag empty to zero and max_segments returns to 6. There is no
// clearing pass: tables are only read at held entries.
module media_segment_window_index (
  input  logic        clk,
  input  logic        rst,
  msw_in_if.sink      item,
  msw_out_if.source   result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration
  logic [4:0]                   max_segments;
  logic [msw_pkg::COUNT_W-1:0]  limit;

  // Stream state
  logic [31:0]                  seq_counter;
  logic [31:0]                  seq_counter_next;
  logic [47:0]                  cumulative_ms;
  logic [47:0]                  cumulative_ms_next;
  logic [15:0]                  max_duration_ms;
  logic [15:0]                  max_duration_ms_next;
  logic [31:0]                  live_seq;
  logic [31:0]                  live_seq_next;
  logic [31:0]                  live_length;
  logic [31:0]                  live_length_next;
  logic [msw_pkg::PCOUNT_W-1:0] live_part_count;
  logic [msw_pkg::PCOUNT_W-1:0] live_part_count_next;
  logic                         low_latency_on;
  logic                         low_latency_on_next;

  // Result register
  logic        out_valid;
  logic        status;
  logic        status_next;
  logic [31:0] seq_out;
  logic [31:0] seq_out_next;
  logic [47:0] seg_start;
  logic [47:0] seg_start_next;
  logic [31:0] part_offset;
  logic [31:0] part_offset_next;
  logic        available;
  logic        available_next;
  logic [6:0]  target_duration_s;
  logic        store_ready;
  logic        ll_ready;
  logic [31:0] first_held_seq;
  logic [4:0]  segment_count;

  logic                accept;
  logic                is_push_seg;
  logic                is_close;
  logic                part_full;
  msw_pkg::ring_req_t  ring_req;
  msw_pkg::ring_stat_t ring_stat;

  // APB: writes complete in the access phase, pready tied high.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == msw_pkg::REG_MAX_SEGMENTS) ? {27'd0, max_segments} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_segments <= msw_pkg::MAX_SEGMENTS_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == msw_pkg::REG_MAX_SEGMENTS)) begin
      max_segments <= pwdata[4:0];
    end
  end

  // Clamp the window size to what the ring can hold.
  always_comb begin
    priority if (max_segments < msw_pkg::MIN_SEGMENTS) begin
      limit = msw_pkg::COUNT_W'(msw_pkg::MIN_SEGMENTS);
    end else if (32'(max_segments) > 32'(msw_pkg::WINDOW_DEPTH)) begin
      limit = msw_pkg::COUNT_W'(msw_pkg::WINDOW_DEPTH);
    end else begin
      limit = msw_pkg::COUNT_W'(max_segments);
    end
  end

  // Take a command whenever the result register is free or being emptied.
  assign item.ready = !out_valid || result.ready;
  assign accept     = item.valid && item.ready;

  assign is_push_seg = (item.command == msw_pkg::CMD_PUSH_SEG);
  assign is_close    = (item.command == msw_pkg::CMD_CLOSE);
  assign part_full   = (32'(live_part_count) >= 32'(msw_pkg::PART_DEPTH));

  always_comb begin
    ring_req.push  = accept && (is_push_seg || is_close);
    ring_req.parts = is_close ? live_part_count : '0;
    ring_req.limit = limit;
  end

  msw_ring u_ring (
    .clk        (clk),
    .rst        (rst),
    .req        (ring_req),
    .query_seq  (item.query_seq),
    .query_part (item.query_part),
    .stat       (ring_stat)
  );

  // Command decode: next state and the command-specific result fields.
  always_comb begin
    seq_counter_next     = seq_counter;
    cumulative_ms_next   = cumulative_ms;
    max_duration_ms_next = max_duration_ms;
    live_seq_next        = live_seq;
    live_length_next     = live_length;
    live_part_count_next = live_part_count;
    low_latency_on_next  = low_latency_on;
    status_next          = msw_pkg::ST_ACCEPTED;
    seq_out_next         = 32'd0;
    seg_start_next       = 48'd0;
    part_offset_next     = 32'd0;
    available_next       = 1'b0;

    unique case (item.command)
      msw_pkg::CMD_PUSH_SEG, msw_pkg::CMD_CLOSE: begin
        seq_out_next       = seq_counter;
        seg_start_next     = cumulative_ms;
        seq_counter_next   = seq_counter + 32'd1;
        cumulative_ms_next = cumulative_ms + 48'(item.duration_ms);
        if (item.duration_ms > max_duration_ms) begin
          max_duration_ms_next = item.duration_ms;
        end
        if (is_close) begin
          // Close the live segment and open the next one.
          live_length_next     = 32'd0;
          live_part_count_next = '0;
          live_seq_next        = seq_counter + 32'd1;
        end
      end
      msw_pkg::CMD_PUSH_PART: begin
        seq_out_next = live_seq;
        if (part_full) begin
          status_next = msw_pkg::ST_PART_FULL;
        end else begin
          part_offset_next     = live_length;
          live_length_next     = live_length + 32'(item.size_bytes);
          live_part_count_next = live_part_count + msw_pkg::PCOUNT_W'(1);
        end
      end
      msw_pkg::CMD_QUERY: begin
        available_next = ((live_seq == item.query_seq) &&
                          (8'(live_part_count) > item.query_part)) || ring_stat.hit;
      end
      msw_pkg::CMD_ENABLE_LL: begin
        low_latency_on_next = (item.duration_ms != 16'd0);
        live_seq_next       = seq_counter;
      end
      default: begin
        // Unknown command: hold all state, report status fields only.
      end
    endcase
  end

  // Stream state advances only on an accepted command.
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_counter     <= '0;
      cumulative_ms   <= '0;
      max_duration_ms <= '0;
      live_seq        <= '0;
      live_length     <= '0;
      live_part_count <= '0;
      low_latency_on  <= 1'b0;
    end else if (accept) begin
      seq_counter     <= seq_counter_next;
      cumulative_ms   <= cumulative_ms_next;
      max_duration_ms <= max_duration_ms_next;
      live_seq        <= live_seq_next;
      live_length     <= live_length_next;
      live_part_count <= live_part_count_next;
      low_latency_on  <= low_latency_on_next;
    end
  end

  // Result valid: set on accept, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload: status fields reflect the state after the command.
  always_ff @(posedge clk) begin
    if (accept) begin
      status            <= status_next;
      seq_out           <= seq_out_next;
      seg_start         <= seg_start_next;
      part_offset       <= part_offset_next;
      available         <= available_next;
      target_duration_s <= msw_pkg::ceil_seconds(max_duration_ms_next);
      store_ready       <= (ring_stat.count_next != '0);
      ll_ready          <= low_latency_on_next &&
                           ((ring_stat.count_next != '0) || (live_part_count_next != '0));
      first_held_seq    <= ring_stat.oldest_next;
      segment_count     <= 5'(ring_stat.count_next);
    end
  end

  assign result.valid             = out_valid;
  assign result.status            = status;
  assign result.seq_out           = seq_out;
  assign result.seg_start         = seg_start;
  assign result.part_offset       = part_offset;
  assign result.available         = available;
  assign result.target_duration_s = target_duration_s;
  assign result.store_ready       = store_ready;
  assign result.ll_ready          = ll_ready;
  assign result.first_held_seq    = first_held_seq;
  assign result.segment_count     = segment_count;

  // Window never holds more than the ring depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(ring_stat.count) <= 32'(msw_pkg::WINDOW_DEPTH))
    else $error("segment count beyond ring depth");

  // Part list never overruns.
  a_parts_bound: assert property (@(posedge clk) disable iff (rst)
    32'(live_part_count) <= 32'(msw_pkg::PART_DEPTH))
    else $error("live part count beyond part list depth");

  // A push into a full window evicts exactly one segment.
  a_evict: assert property (@(posedge clk) disable iff (rst)
    (ring_req.push && (ring_stat.count >= limit)) |=>
      (ring_stat.oldest == $past(ring_stat.oldest) + 32'd1) &&
      (ring_stat.count == $past(ring_stat.count)))
    else $error("eviction did not retire the oldest segment");

  // Every segment push hands out the next sequence number.
  a_seq_advance: assert property (@(posedge clk) disable iff (rst)
    ring_req.push |=> (seq_counter == $past(seq_counter) + 32'd1) &&
                      (seq_out == $past(seq_counter)))
    else $error("sequence number not advanced on push");

endmodule

@@ test/msw_window_checker.sv @@
// Checker for the media segment window index: watches the command, result and APB
// channels, predicts each result and compares it field by field.
// Depends on msw_pkg, msw_in_if and msw_out_if.
`timescale 1ns / 100ps

module msw_window_checker (
  input  logic        clk,
  input  logic        rst,
  msw_in_if           item,
  msw_out_if          result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          failures,
  output int          pending
);

  localparam logic [2:0] MAX_SEG_ADDR = {msw_pkg::REG_MAX_SEGMENTS, 2'b00};

  typedef struct packed {
    logic        status;
    logic [31:0] seq;
    logic [47:0] start;
    logic [31:0] offset;
    logic        available;
    logic [6:0]  target_s;
    logic        store_ready;
    logic        ll_ready;
    logic [31:0] oldest;
    logic [4:0]  count;
  } window_answer_t;

  // Predicted window state
  logic [4:0]                   max_seg_reg;
  logic [msw_pkg::SLOT_W-1:0]   head;
  logic [msw_pkg::COUNT_W-1:0]  held;
  logic [31:0]                  first_seq;
  logic [31:0]                  seq_counter;
  logic [47:0]                  elapsed_ms;
  logic [15:0]                  longest_ms;
  logic [31:0]                  live_seq;
  logic [31:0]                  open_bytes;
  logic [msw_pkg::PCOUNT_W-1:0] open_parts;
  logic                         ll_on;
  logic [msw_pkg::PCOUNT_W-1:0] seg_parts [msw_pkg::WINDOW_DEPTH];

  window_answer_t awaited_answers [$];

  function automatic logic [msw_pkg::COUNT_W-1:0] window_limit();
    if (max_seg_reg < msw_pkg::MIN_SEGMENTS) return msw_pkg::COUNT_W'(msw_pkg::MIN_SEGMENTS);
    if (max_seg_reg > msw_pkg::WINDOW_DEPTH) return msw_pkg::COUNT_W'(msw_pkg::WINDOW_DEPTH);
    return msw_pkg::COUNT_W'(max_seg_reg);
  endfunction

  // Evict the oldest segment when the window is full, then append.
  task automatic store_segment(input logic [15:0] dur,
                               input logic [msw_pkg::PCOUNT_W-1:0] parts,
                               inout window_answer_t a);
    if (held >= window_limit() && held != 0) begin
      head      = head + 1'b1;
      held      = held - 1'b1;
      first_seq = first_seq + 32'd1;
    end
    seg_parts[msw_pkg::SLOT_W'(head + held)] = parts;
    a.seq       = seq_counter;
    a.start     = elapsed_ms;
    seq_counter = seq_counter + 32'd1;
    elapsed_ms  = elapsed_ms + 48'(dur);
    held        = held + 1'b1;
    if (dur > longest_ms) longest_ms = dur;
  endtask

  task automatic step_window(input logic [2:0] cmd, input logic [26:0] size,
                             input logic [15:0] dur, input logic [31:0] query_seq,
                             input logic [7:0] query_part, output window_answer_t a);
    logic [31:0]                  last;
    logic [31:0]                  rel;
    logic [msw_pkg::PCOUNT_W-1:0] pc;
    int                           secs;
    a = '0;
    case (cmd)
      msw_pkg::CMD_PUSH_SEG: begin
        store_segment(dur, '0, a);
      end
      msw_pkg::CMD_PUSH_PART: begin
        a.seq = live_seq;
        if (open_parts >= msw_pkg::PART_DEPTH) begin
          a.status = msw_pkg::ST_PART_FULL;
        end else begin
          a.offset   = open_bytes;
          open_bytes = open_bytes + 32'(size);
          open_parts = open_parts + 1'b1;
        end
      end
      msw_pkg::CMD_CLOSE: begin
        store_segment(dur, open_parts, a);
        open_bytes = '0;
        open_parts = '0;
        live_seq   = seq_counter;
      end
      msw_pkg::CMD_QUERY: begin
        if (live_seq == query_seq && open_parts > query_part) begin
          a.available = 1'b1;
        end else if (held != 0) begin
          last = first_seq + 32'(held) - 32'd1;
          if (query_seq >= first_seq && query_seq <= last) begin
            rel = query_seq - first_seq;
            pc  = seg_parts[msw_pkg::SLOT_W'(head + rel[msw_pkg::SLOT_W-1:0])];
            a.available = (pc > query_part) || (query_part == 8'd0 && pc == 0);
          end
        end
      end
      msw_pkg::CMD_ENABLE_LL: begin
        ll_on    = (dur != 16'd0);
        live_seq = seq_counter;
      end
      default: ;
    endcase
    secs = (int'(longest_ms) + 999) / 1000;
    if (secs < 1) secs = 1;
    a.target_s    = 7'(secs);
    a.store_ready = (held != 0);
    a.ll_ready    = ll_on && (held != 0 || open_parts != 0);
    a.oldest      = first_seq;
    a.count       = 5'(held);
  endtask

  task automatic check_field(input string name, input logic [47:0] want,
                             input logic [47:0] got);
    if (got !== want) begin
      failures++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    window_answer_t got;
    window_answer_t want;
    if (rst) begin
      max_seg_reg = msw_pkg::MAX_SEGMENTS_RESET;
      head        = '0;
      held        = '0;
      first_seq   = '0;
      seq_counter = '0;
      elapsed_ms  = '0;
      longest_ms  = '0;
      live_seq    = '0;
      open_bytes  = '0;
      open_parts  = '0;
      ll_on       = 1'b0;
      foreach (seg_parts[i]) seg_parts[i] = '0;
      awaited_answers.delete();
      failures = 0;
    end else begin
      // A result is registered behind its command, so take results first.
      if (result.valid && result.ready) begin
        got.status      = result.status;
        got.seq         = result.seq_out;
        got.start       = result.seg_start;
        got.offset      = result.part_offset;
        got.available   = result.available;
        got.target_s    = result.target_duration_s;
        got.store_ready = result.store_ready;
        got.ll_ready    = result.ll_ready;
        got.oldest      = result.first_held_seq;
        got.count       = result.segment_count;
        if (awaited_answers.size() == 0) begin
          failures++;
          $display("%0t: result with none expected, expected nothing, got %0h",
                   $time, got);
        end else begin
          want = awaited_answers.pop_front();
          check_field("status", 48'(want.status), 48'(got.status));
          check_field("seq_out", 48'(want.seq), 48'(got.seq));
          check_field("seg_start", want.start, got.start);
          check_field("part_offset", 48'(want.offset), 48'(got.offset));
          check_field("available", 48'(want.available), 48'(got.available));
          check_field("target_duration_s", 48'(want.target_s), 48'(got.target_s));
          check_field("store_ready", 48'(want.store_ready), 48'(got.store_ready));
          check_field("ll_ready", 48'(want.ll_ready), 48'(got.ll_ready));
          check_field("first_held_seq", 48'(want.oldest), 48'(got.oldest));
          check_field("segment_count", 48'(want.count), 48'(got.count));
        end
      end
      if (item.valid && item.ready) begin
        step_window(item.command, item.size_bytes, item.duration_ms, item.query_seq,
                    item.query_part, want);
        awaited_answers.push_back(want);
      end
      if (psel && penable && pwrite && pready && paddr == MAX_SEG_ADDR)
        max_seg_reg = pwdata[4:0];
    end
    pending = awaited_answers.size();
  end

endmodule

@@ test/media_segment_window_index_test.sv @@
// Testbench top for the media segment window index: clock, reset, command
// stimulus, result stalls, register writes and the verdict.
// Depends on msw_pkg, msw_in_if, msw_out_if, msw_window_checker and the block.
`timescale 1ns / 100ps

module media_segment_window_index_test;

  localparam logic [2:0] MAX_SEG_ADDR = {msw_pkg::REG_MAX_SEGMENTS, 2'b00};

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int failures;
  int pending;

  // Sender bookkeeping: transactions sent, burst state and a running guess of
  // the sequence numbers, used only to aim queries at held segments.
  int          sent;
  int          burst_left;
  logic [31:0] seq_guess;
  logic [31:0] live_guess;
  logic [31:0] stall_clock;

  msw_in_if  item_ch ();
  msw_out_if result_ch ();

  media_segment_window_index i_dut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  msw_window_checker i_check (
    .clk      (clk),
    .rst      (rst),
    .item     (item_ch),
    .result   (result_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .pready   (pready),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .failures (failures),
    .pending  (pending)
  );

  always #1 clk = ~clk;

  // Result side stalls on its own pattern: bits 8:7 of a free-running counter pick the mode
  // among always ready, coin-flip, mostly stalled and a fixed 5-of-8 stall.
  always @(negedge clk) begin
    stall_clock <= stall_clock + 32'd1;
    case (stall_clock[8:7])
      2'd0: result_ch.ready <= 1'b1;
      2'd1: result_ch.ready <= 1'($urandom_range(0, 1));
      2'd2: result_ch.ready <= ($urandom_range(0, 3) == 0);
      default: result_ch.ready <= (stall_clock[2:0] >= 3'd5);
    endcase
  end

  // Hard stop, far beyond the slowest correct run.
  initial begin
    #400000;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [26:0] random_size();
    case ($urandom_range(0, 3))
      0: return 27'($urandom);
      1: return 27'($urandom_range(0, 5000));
      2: return $urandom_range(0, 1) ? 27'h7FF_FFFF : 27'd0;
      default: return 27'($urandom_range(0, 1 << 20));
    endcase
  endfunction

  function automatic logic [15:0] random_dur();
    case ($urandom_range(0, 4))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 12000));
      2: return 16'($urandom_range(0, 2000));
      3: return 16'($urandom_range(1, 3) * 1000 + $urandom_range(0, 1));
      default: return $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
    endcase
  endfunction

  // Aim mostly at the live segment and the recent window, now and then anywhere.
  function automatic logic [31:0] random_query_seq();
    case ($urandom_range(0, 3))
      0: return live_guess;
      1: return seq_guess - 32'($urandom_range(1, 20));
      2: return seq_guess - 32'($urandom_range(0, 4));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] random_query_part();
    return ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 17));
  endfunction

  // Offer one command and hold it until it is taken. Called at a falling edge;
  // returns at a falling edge with valid still high inside a burst, so the next
  // command follows without a bubble.
  task automatic send_command(input logic [2:0] cmd, input logic [26:0] size,
                              input logic [15:0] dur, input logic indep,
                              input logic [31:0] query_seq, input logic [7:0] query_part);
    item_ch.valid       <= 1'b1;
    item_ch.command     <= cmd;
    item_ch.size_bytes  <= size;
    item_ch.duration_ms <= dur;
    item_ch.independent <= indep;
    item_ch.query_seq   <= query_seq;
    item_ch.query_part  <= query_part;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    sent++;
    if (cmd == msw_pkg::CMD_PUSH_SEG || cmd == msw_pkg::CMD_CLOSE)
      seq_guess = seq_guess + 32'd1;
    if (cmd == msw_pkg::CMD_CLOSE || cmd == msw_pkg::CMD_ENABLE_LL) live_guess = seq_guess;
    @(negedge clk);
    if (burst_left == 0) begin
      // Drop valid for a gap, then pick the next burst; long bursts leave
      // stretches with no idling at all.
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  // Hold off the sender until every expected result has come back, plus a margin.
  task automatic pause_until_quiet();
    item_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_max_segments(input logic [4:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MAX_SEG_ADDR;
    pwdata  <= {27'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_part();
    send_command(msw_pkg::CMD_PUSH_PART, random_size(), random_dur(),
                 1'($urandom_range(0, 1)), $urandom, 8'($urandom));
  endtask

  task automatic send_query(input logic [31:0] query_seq, input logic [7:0] query_part);
    send_command(msw_pkg::CMD_QUERY, random_size(), random_dur(),
                 1'($urandom_range(0, 1)), query_seq, query_part);
  endtask

  // Random traffic, mostly well-formed low-latency segments: optional enable,
  // a run of parts (sometimes past the part list) with queries in between,
  // a close and a look back at the segment just closed.
  task automatic run_random(input int quota);
    int          stop_at;
    int          pick;
    int          n_parts;
    logic [31:0] closed_seq;
    stop_at = sent + quota;
    while (sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        if ($urandom_range(0, 1))
          send_command(msw_pkg::CMD_ENABLE_LL, random_size(),
                       ($urandom_range(0, 3) == 0) ? 16'd0 : random_dur(),
                       1'($urandom_range(0, 1)), $urandom, 8'($urandom));
        n_parts = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 19)
                                              : $urandom_range(0, 6);
        for (int k = 0; k < n_parts; k++) begin
          send_part();
          if ($urandom_range(0, 3) == 0)
            send_query(live_guess, 8'($urandom_range(0, k + 2)));
        end
        send_command(msw_pkg::CMD_CLOSE, random_size(), random_dur(),
                     1'($urandom_range(0, 1)), $urandom, 8'($urandom));
        closed_seq = seq_guess - 32'd1;
        if ($urandom_range(0, 1))
          send_query(closed_seq, 8'($urandom_range(0, n_parts + 1)));
      end else if (pick < 65) begin
        send_command(msw_pkg::CMD_PUSH_SEG, random_size(), random_dur(),
                     1'($urandom_range(0, 1)), $urandom, 8'($urandom));
      end else if (pick < 82) begin
        send_query(random_query_seq(), random_query_part());
      end else if (pick < 90) begin
        send_command(msw_pkg::CMD_ENABLE_LL, random_size(),
                     ($urandom_range(0, 2) == 0) ? 16'd0 : random_dur(),
                     1'($urandom_range(0, 1)), $urandom, 8'($urandom));
      end else if (pick < 96) begin
        send_command(msw_pkg::CMD_CLOSE, random_size(), random_dur(),
                     1'($urandom_range(0, 1)), $urandom, 8'($urandom));
      end else begin
        // Codes above the last defined command change nothing.
        send_command(msw_pkg::CMD_ENABLE_LL + 3'($urandom_range(1, 3)), random_size(),
                     16'($urandom), 1'($urandom_range(0, 1)), $urandom, 8'($urandom));
      end
    end
  endtask

  initial begin
    logic [4:0] settings [8];
    rst                 = 1'b1;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    item_ch.valid       = 1'b0;
    item_ch.command     = msw_pkg::CMD_PUSH_SEG;
    item_ch.size_bytes  = '0;
    item_ch.duration_ms = '0;
    item_ch.independent = 1'b0;
    item_ch.query_seq   = '0;
    item_ch.query_part  = '0;
    result_ch.ready     = 1'b0;
    stall_clock         = '0;
    sent                = 0;
    burst_left          = 0;
    seq_guess           = '0;
    live_guess          = '0;

    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Directed part, window size at its reset value.
    // Query an empty store, then close a live segment that has no parts.
    send_query(32'd0, 8'd0);
    send_command(msw_pkg::CMD_CLOSE, 27'd0, 16'd0, 1'b0, '0, '0);
    // Largest segment and duration, then the smallest.
    send_command(msw_pkg::CMD_PUSH_SEG, 27'h7FF_FFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 8'hFF);
    send_command(msw_pkg::CMD_PUSH_SEG, 27'd0, 16'd0, 1'b0, '0, '0);
    // Enable with a zero target leaves low latency off; then switch it on.
    send_command(msw_pkg::CMD_ENABLE_LL, 27'd0, 16'd0, 1'b0, '0, '0);
    send_command(msw_pkg::CMD_ENABLE_LL, 27'h7FF_FFFF, 16'hFFFF, 1'b1, '0, '0);
    // Fill the part list and push one more, which must be refused.
    for (int k = 0; k <= msw_pkg::PART_DEPTH; k++)
      send_command(msw_pkg::CMD_PUSH_PART, (k == 0) ? 27'h7FF_FFFF : random_size(),
                   random_dur(), 1'(k), $urandom, 8'($urandom));
    // Last part of the live segment, and part 0 of a held segment with no parts.
    send_query(live_guess, 8'(msw_pkg::PART_DEPTH - 1));
    send_query(32'd2, 8'd0);
    send_command(msw_pkg::CMD_CLOSE, 27'd0, 16'd1000, 1'b0, '0, '0);
    send_command(3'd7, 27'h7FF_FFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 8'hFF);
    send_query(seq_guess - 32'd1, 8'(msw_pkg::PART_DEPTH - 1));

    // Window sizes: full depth, then a shrink below the held count, the clamped
    // extremes, the bounds and a couple of ordinary values.
    settings = '{5'd16, 5'd3, 5'd0, 5'd31, 5'd2, 5'd1, 5'd9, 5'd16};
    settings[6] = 5'($urandom_range(4, 15));
    foreach (settings[p]) begin
      pause_until_quiet();
      write_max_segments(settings[p]);
      run_random(118);
    end

    pause_until_quiet();
    if (failures == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
